>>> hdl/pcrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrt_pkg
// Shared types and constants for the placed-circuit runtime evaluator.
// ----------------------------------------------------------------------------
package pcrt_pkg;

   localparam int TIME_W    = 48;
   localparam int AMT_W     = 32;
   localparam int IDX_W     = 4;
   localparam int CNT_W     = 5;
   localparam int CSR_IDX_W = 4;
   localparam int RSP_DEPTH = 8;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_QUBIT_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUCLEUS_COUNT = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      REQ_CLEAR       = 3'd0,
      REQ_LOAD_PLACE  = 3'd1,
      REQ_LOAD_SINGLE = 3'd2,
      REQ_LOAD_PAIR   = 3'd3,
      REQ_GATE1       = 3'd4,
      REQ_GATE2       = 3'd5,
      REQ_REPORT      = 3'd6
   } req_type_type;

   typedef struct packed {
      req_type_type       kind;
      logic [IDX_W-1:0]   qa;
      logic [IDX_W-1:0]   qb;
      logic               placed;
      logic [AMT_W-1:0]   amount;
   } req_beat_type;

   typedef struct packed {
      logic               valid;
      req_type_type       kind;
      logic [IDX_W-1:0]   qa;
      logic [IDX_W-1:0]   qb;
      logic               ok_a;
      logic               ok_b;
      logic [TIME_W-1:0]  cost;
      logic               cost_sat;
   } cost_beat_type;

   typedef struct packed {
      logic [TIME_W-1:0]  runtime;
      logic               aborted;
      logic               saturated;
   } result_type;

endpackage

>>> hdl/pcrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrt_ram
// Generic RAM: one write port, two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module pcrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hdl/pcrt_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrt_lookup
// Placement and weight stores; placement read, weight read, cost multiply, scale and clip.
// ----------------------------------------------------------------------------
module pcrt_lookup import pcrt_pkg::*; #(
   parameter int MAX_QUBITS    = 16,
   parameter int MAX_NUCLEI    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  req_beat_type     req,
   input  logic [CNT_W-1:0] qubit_count,
   input  logic [CNT_W-1:0] nucleus_count,
   output cost_beat_type    beat,
   output logic             gate_busy
);

   localparam int QW         = $clog2(MAX_QUBITS);
   localparam int NW         = $clog2(MAX_NUCLEI);
   localparam int PAIR_DEPTH = MAX_NUCLEI * MAX_NUCLEI;
   localparam int WDEPTH     = PAIR_DEPTH + MAX_NUCLEI;
   localparam int WAW        = $clog2(WDEPTH);
   localparam int PROD_W     = 2 * AMT_W;

   // accept side
   logic [31:0]      qa_ext, qb_ext;
   logic [QW-1:0]    qa_idx, qb_idx;
   logic [NW-1:0]    na_req, nb_req;
   logic             qa_fits, na_fits, nb_fits;
   logic             place_wr, stage_kind;
   logic [IDX_W-1:0] place_data;
   logic             w_wr;
   logic [WAW-1:0]   w_wr_addr;
   logic [MAX_QUBITS-1:0] pv_ff, pv_in;

   assign qa_ext  = 32'(req.qa);
   assign qb_ext  = 32'(req.qb);
   assign qa_idx  = qa_ext[QW-1:0];
   assign qb_idx  = qb_ext[QW-1:0];
   assign na_req  = qa_ext[NW-1:0];
   assign nb_req  = qb_ext[NW-1:0];
   assign qa_fits = qa_ext < 32'(MAX_QUBITS);
   assign na_fits = qa_ext < 32'(MAX_NUCLEI);
   assign nb_fits = qb_ext < 32'(MAX_NUCLEI);

   assign place_wr   = req_accept && (req.kind == REQ_LOAD_PLACE) && qa_fits;
   assign place_data = req.placed ? req.qb : '0;

   always_comb begin
      pv_in = pv_ff;
      if (place_wr) begin
         pv_in[qa_idx] = req.placed;
      end
   end

   always_comb begin
      w_wr      = 1'b0;
      w_wr_addr = WAW'(na_req) * WAW'(MAX_NUCLEI) + WAW'(nb_req);
      case (req.kind)
         REQ_LOAD_SINGLE: begin
            w_wr      = req_accept && na_fits;
            w_wr_addr = WAW'(PAIR_DEPTH) + WAW'(na_req);
         end
         REQ_LOAD_PAIR: begin
            w_wr = req_accept && na_fits && nb_fits;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (req.kind)
         REQ_CLEAR, REQ_GATE1, REQ_GATE2, REQ_REPORT: stage_kind = 1'b1;
         default:                                     stage_kind = 1'b0;
      endcase
   end

   // stage 1: placement data
   logic             s1_valid_ff;
   req_type_type     s1_kind_ff;
   logic [IDX_W-1:0] s1_qa_ff, s1_qb_ff;
   logic [AMT_W-1:0] s1_amount_ff;
   logic             s1_pva_ff, s1_pvb_ff;
   logic [IDX_W-1:0] pn_a, pn_b;
   logic [31:0]      s1_qa_ext, s1_qb_ext, pn_a_ext, pn_b_ext;
   logic [NW-1:0]    na1, nb1;
   logic             ok_a1, ok_b1;
   logic [WAW-1:0]   w_rd_addr;

   pcrt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_QUBITS)) u_place (
      .clock     (clock),
      .wr_en     (place_wr),
      .wr_addr   (qa_idx),
      .wr_data   (place_data),
      .rd_addr_a (qa_idx),
      .rd_data_a (pn_a),
      .rd_addr_b (qb_idx),
      .rd_data_b (pn_b)
   );

   assign s1_qa_ext = 32'(s1_qa_ff);
   assign s1_qb_ext = 32'(s1_qb_ff);
   assign pn_a_ext  = 32'(pn_a);
   assign pn_b_ext  = 32'(pn_b);
   assign na1       = pn_a_ext[NW-1:0];
   assign nb1       = pn_b_ext[NW-1:0];

   assign ok_a1 = ({1'b0, s1_qa_ff} < qubit_count) && (s1_qa_ext < 32'(MAX_QUBITS))
                  && s1_pva_ff && ({1'b0, pn_a} < nucleus_count)
                  && (pn_a_ext < 32'(MAX_NUCLEI));
   assign ok_b1 = ({1'b0, s1_qb_ff} < qubit_count) && (s1_qb_ext < 32'(MAX_QUBITS))
                  && s1_pvb_ff && ({1'b0, pn_b} < nucleus_count)
                  && (pn_b_ext < 32'(MAX_NUCLEI));

   assign w_rd_addr = (s1_kind_ff == REQ_GATE1) ? WAW'(PAIR_DEPTH) + WAW'(na1)
                                                 : WAW'(na1) * WAW'(MAX_NUCLEI) + WAW'(nb1);

   // stage 2: weight data, multiply
   logic             s2_valid_ff;
   req_type_type     s2_kind_ff;
   logic [IDX_W-1:0] s2_qa_ff, s2_qb_ff;
   logic             s2_ok_a_ff, s2_ok_b_ff;
   logic [AMT_W-1:0] s2_amount_ff;
   logic [AMT_W-1:0] w_rd;
   logic [PROD_W-1:0] prod_in;

   pcrt_ram #(.WIDTH(AMT_W), .DEPTH(WDEPTH)) u_weight (
      .clock     (clock),
      .wr_en     (w_wr),
      .wr_addr   (w_wr_addr),
      .wr_data   (req.amount),
      .rd_addr_a (w_rd_addr),
      .rd_data_a (w_rd),
      .rd_addr_b (w_rd_addr),
      .rd_data_b ()
   );

   assign prod_in = PROD_W'(w_rd) * PROD_W'(s2_amount_ff);

   // stage 3: scale and clip
   logic              s3_valid_ff;
   req_type_type      s3_kind_ff;
   logic [IDX_W-1:0]  s3_qa_ff, s3_qb_ff;
   logic              s3_ok_a_ff, s3_ok_b_ff;
   logic [PROD_W-1:0] s3_prod_ff;
   logic [PROD_W-1:0] scaled;
   logic              cost_sat;

   assign scaled   = s3_prod_ff >> FRACTION_BITS;
   assign cost_sat = |scaled[PROD_W-1:TIME_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         pv_ff       <= pv_in;
         s1_valid_ff <= req_accept && stage_kind;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff   <= req.kind;
      s1_qa_ff     <= req.qa;
      s1_qb_ff     <= req.qb;
      s1_amount_ff <= req.amount;
      s1_pva_ff    <= pv_ff[qa_idx];
      s1_pvb_ff    <= pv_ff[qb_idx];
      s2_kind_ff   <= s1_kind_ff;
      s2_qa_ff     <= s1_qa_ff;
      s2_qb_ff     <= s1_qb_ff;
      s2_ok_a_ff   <= ok_a1;
      s2_ok_b_ff   <= ok_b1;
      s2_amount_ff <= s1_amount_ff;
      s3_kind_ff   <= s2_kind_ff;
      s3_qa_ff     <= s2_qa_ff;
      s3_qb_ff     <= s2_qb_ff;
      s3_ok_a_ff   <= s2_ok_a_ff;
      s3_ok_b_ff   <= s2_ok_b_ff;
      s3_prod_ff   <= prod_in;
   end

   always_comb begin
      beat.valid    = s3_valid_ff;
      beat.kind     = s3_kind_ff;
      beat.qa       = s3_qa_ff;
      beat.qb       = s3_qb_ff;
      beat.ok_a     = s3_ok_a_ff;
      beat.ok_b     = s3_ok_b_ff;
      beat.cost_sat = cost_sat;
      beat.cost     = cost_sat ? '1 : scaled[TIME_W-1:0];
   end

   assign gate_busy = s1_valid_ff && ((s1_kind_ff == REQ_GATE1) || (s1_kind_ff == REQ_GATE2));

endmodule

>>> hdl/pcrt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrt_update
// Finish-time store with read-modify-write, run flags and longest time.
// ----------------------------------------------------------------------------
module pcrt_update import pcrt_pkg::*; #(
   parameter int MAX_QUBITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cost_beat_type beat,
   output logic          rsp_push,
   output result_type    rsp_data
);

   localparam int QW = $clog2(MAX_QUBITS);

   logic [31:0]       qa3_ext, qb3_ext;
   logic [QW-1:0]     qa3_idx, qb3_idx;

   logic              s4_valid_ff;
   req_type_type      s4_kind_ff;
   logic [IDX_W-1:0]  s4_qa_ff, s4_qb_ff;
   logic              s4_ok_a_ff, s4_ok_b_ff;
   logic [TIME_W-1:0] s4_cost_ff;
   logic              s4_cost_sat_ff;
   logic              s4_tva_ff, s4_tvb_ff;
   logic [31:0]       qa4_ext, qb4_ext;
   logic [QW-1:0]     qa4_idx, qb4_idx;

   logic [MAX_QUBITS-1:0] tvalid_ff, tvalid_in;
   logic              abort_ff, abort_in;
   logic              sat_ff, sat_in;
   logic              rec_v_ff, rec_v_in;
   logic [IDX_W-1:0]  rec_qa_ff, rec_qa_in, rec_qb_ff, rec_qb_in;
   logic [TIME_W-1:0] rec_t_ff, rec_t_in;

   logic              s5_upd_ff, s5_upd_in;
   logic              s5_wrb_ff, s5_wrb_in;
   logic              s5_clear_ff, s5_clear_in;
   logic              s5_report_ff, s5_report_in;
   logic [TIME_W-1:0] s5_t_ff;
   logic [QW-1:0]     s5_qb_ff;
   logic              s5_abort_ff, s5_sat_ff;
   logic [TIME_W-1:0] longest_ff, longest_in;

   logic [TIME_W-1:0] rd_a, rd_b, ta, tb, base, t_new;
   logic [TIME_W:0]   sum;
   logic              sum_sat, hit_a, hit_b, clear4, wr4;
   logic              t_wr;
   logic [QW-1:0]     t_wr_addr;
   logic [TIME_W-1:0] t_wr_data;

   assign qa3_ext = 32'(beat.qa);
   assign qb3_ext = 32'(beat.qb);
   assign qa3_idx = qa3_ext[QW-1:0];
   assign qb3_idx = qb3_ext[QW-1:0];
   assign qa4_ext = 32'(s4_qa_ff);
   assign qb4_ext = 32'(s4_qb_ff);
   assign qa4_idx = qa4_ext[QW-1:0];
   assign qb4_idx = qb4_ext[QW-1:0];

   pcrt_ram #(.WIDTH(TIME_W), .DEPTH(MAX_QUBITS)) u_time (
      .clock     (clock),
      .wr_en     (t_wr),
      .wr_addr   (t_wr_addr),
      .wr_data   (t_wr_data),
      .rd_addr_a (qa3_idx),
      .rd_data_a (rd_a),
      .rd_addr_b (qb3_idx),
      .rd_data_b (rd_b)
   );

   assign clear4 = s4_valid_ff && (s4_kind_ff == REQ_CLEAR);

   // the previous gate may still be in flight to memory
   assign hit_a = rec_v_ff && ((s4_qa_ff == rec_qa_ff) || (s4_qa_ff == rec_qb_ff));
   assign hit_b = rec_v_ff && ((s4_qb_ff == rec_qa_ff) || (s4_qb_ff == rec_qb_ff));
   assign ta    = hit_a ? rec_t_ff : (s4_tva_ff ? rd_a : '0);
   assign tb    = hit_b ? rec_t_ff : (s4_tvb_ff ? rd_b : '0);

   assign base    = ((s4_kind_ff == REQ_GATE2) && (tb > ta)) ? tb : ta;
   assign sum     = {1'b0, base} + {1'b0, s4_cost_ff};
   assign sum_sat = sum[TIME_W];
   assign t_new   = sum_sat ? '1 : sum[TIME_W-1:0];

   always_comb begin
      wr4          = 1'b0;
      abort_in     = abort_ff;
      sat_in       = sat_ff;
      rec_v_in     = rec_v_ff;
      rec_qa_in    = rec_qa_ff;
      rec_qb_in    = rec_qb_ff;
      rec_t_in     = rec_t_ff;
      s5_upd_in    = 1'b0;
      s5_wrb_in    = 1'b0;
      s5_clear_in  = 1'b0;
      s5_report_in = 1'b0;
      if (s4_valid_ff) begin
         case (s4_kind_ff)
            REQ_CLEAR: begin
               abort_in    = 1'b0;
               sat_in      = 1'b0;
               rec_v_in    = 1'b0;
               s5_clear_in = 1'b1;
            end
            REQ_GATE1: begin
               if (!abort_ff && s4_ok_a_ff) begin
                  wr4       = 1'b1;
                  sat_in    = sat_ff | s4_cost_sat_ff | sum_sat;
                  rec_v_in  = 1'b1;
                  rec_qa_in = s4_qa_ff;
                  rec_qb_in = s4_qa_ff;
                  rec_t_in  = t_new;
                  s5_upd_in = 1'b1;
               end
            end
            REQ_GATE2: begin
               if (!abort_ff) begin
                  if (!(s4_ok_a_ff && s4_ok_b_ff)) begin
                     abort_in = 1'b1;
                  end else begin
                     wr4       = 1'b1;
                     sat_in    = sat_ff | s4_cost_sat_ff | sum_sat;
                     rec_v_in  = 1'b1;
                     rec_qa_in = s4_qa_ff;
                     rec_qb_in = s4_qb_ff;
                     rec_t_in  = t_new;
                     s5_upd_in = 1'b1;
                     s5_wrb_in = 1'b1;
                  end
               end
            end
            REQ_REPORT: begin
               s5_report_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // second write of a two-qubit gate goes from the stage 5 registers
   assign t_wr      = wr4 || s5_wrb_ff;
   assign t_wr_addr = wr4 ? qa4_idx : s5_qb_ff;
   assign t_wr_data = wr4 ? t_new : s5_t_ff;

   always_comb begin
      if (clear4) begin
         tvalid_in = '0;
      end else begin
         tvalid_in = tvalid_ff;
         if (wr4) begin
            tvalid_in[qa4_idx] = 1'b1;
         end
         if (s5_wrb_ff) begin
            tvalid_in[s5_qb_ff] = 1'b1;
         end
      end
   end

   always_comb begin
      if (s5_clear_ff) begin
         longest_in = '0;
      end else if (s5_upd_ff && (s5_t_ff > longest_ff)) begin
         longest_in = s5_t_ff;
      end else begin
         longest_in = longest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         tvalid_ff    <= '0;
         abort_ff     <= 1'b0;
         sat_ff       <= 1'b0;
         rec_v_ff     <= 1'b0;
         s5_upd_ff    <= 1'b0;
         s5_wrb_ff    <= 1'b0;
         s5_clear_ff  <= 1'b0;
         s5_report_ff <= 1'b0;
         longest_ff   <= '0;
      end else begin
         s4_valid_ff  <= beat.valid;
         tvalid_ff    <= tvalid_in;
         abort_ff     <= abort_in;
         sat_ff       <= sat_in;
         rec_v_ff     <= rec_v_in;
         s5_upd_ff    <= s5_upd_in;
         s5_wrb_ff    <= s5_wrb_in;
         s5_clear_ff  <= s5_clear_in;
         s5_report_ff <= s5_report_in;
         longest_ff   <= longest_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_kind_ff     <= beat.kind;
      s4_qa_ff       <= beat.qa;
      s4_qb_ff       <= beat.qb;
      s4_ok_a_ff     <= beat.ok_a;
      s4_ok_b_ff     <= beat.ok_b;
      s4_cost_ff     <= beat.cost;
      s4_cost_sat_ff <= beat.cost_sat;
      s4_tva_ff      <= tvalid_ff[qa3_idx] && !clear4;
      s4_tvb_ff      <= tvalid_ff[qb3_idx] && !clear4;
      rec_qa_ff      <= rec_qa_in;
      rec_qb_ff      <= rec_qb_in;
      rec_t_ff       <= rec_t_in;
      s5_t_ff        <= t_new;
      s5_qb_ff       <= qb4_idx;
      s5_abort_ff    <= abort_ff;
      s5_sat_ff      <= sat_ff;
   end

   assign rsp_push           = s5_report_ff;
   assign rsp_data.runtime   = s5_abort_ff ? '0 : longest_ff;
   assign rsp_data.aborted   = s5_abort_ff;
   assign rsp_data.saturated = s5_sat_ff;

   a_single_write_port: assert property (@(posedge clock) disable iff (reset)
      !(wr4 && s5_wrb_ff))
      else $error("time store written twice in one cycle");

   a_abort_source: assert property (@(posedge clock) disable iff (reset)
      $rose(abort_ff) |-> $past(s4_valid_ff && (s4_kind_ff == REQ_GATE2)))
      else $error("abort raised by something other than a two-qubit gate");

   a_clear_flags: assert property (@(posedge clock) disable iff (reset)
      clear4 |=> (!abort_ff && !sat_ff && (tvalid_ff == '0) && !rec_v_ff))
      else $error("clear left run state behind");

endmodule

>>> hdl/pcrt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrt_fifo
// Result queue between the update pipeline and the response channel.
// ----------------------------------------------------------------------------
module pcrt_fifo import pcrt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output logic       out_valid,
   output result_type out_data
);

   localparam int PW = $clog2(RSP_DEPTH);

   result_type          entries_ff [RSP_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff;
   logic                pop_go;

   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];
   assign pop_go    = out_valid && pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop_go) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop_go);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/placed_circuit_runtime_dp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placed_circuit_runtime_dp_top
// Runtime of a placed gate circuit (ASAP critical path) in Q32.16 fixed point.
// Clears, loads and reports are taken one per cycle; a gate is not taken while
// a gate is in the placement-read stage, since the single write port of the
// finish-time memory also takes a two-qubit gate's second write. Items pass a
// five-stage pipeline (placement read, weight read, multiply, time read,
// update); a two-qubit gate writes its second time in the cycle after the
// update. rsp_valid rises once a report has passed the pipeline into the result
// queue. Up to eight reports may be outstanding; beyond that req_ready drops
// for reports until rsp beats are taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module placed_circuit_runtime_dp_top import pcrt_pkg::*; #(
   parameter int MAX_QUBITS    = 16,
   parameter int MAX_NUCLEI    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_type,
   input  logic [IDX_W-1:0]     req_first_index,
   input  logic [IDX_W-1:0]     req_second_index,
   input  logic                 req_placed,
   input  logic [AMT_W-1:0]     req_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TIME_W-1:0]    rsp_runtime,
   output logic                 rsp_aborted,
   output logic                 rsp_saturated,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data
);

   req_type_type         req_kind;
   req_beat_type         req_beat;
   cost_beat_type        cost_beat;
   result_type           push_data, out_data;
   logic                 push, gate_busy, req_accept, rsp_accept;
   logic                 is_gate, is_report;
   logic [CNT_W-1:0]     qubit_count_ff, nucleus_count_ff;
   logic [RSP_CNT_W-1:0] outstanding_ff;

   assign req_kind  = req_type_type'(req_type);
   assign is_gate   = (req_kind == REQ_GATE1) || (req_kind == REQ_GATE2);
   assign is_report = req_kind == REQ_REPORT;

   assign req_ready  = !(is_gate && gate_busy)
                       && !(is_report && (outstanding_ff == RSP_CNT_W'(RSP_DEPTH)));
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;
   assign csr_ready  = 1'b1;

   assign req_beat.kind   = req_kind;
   assign req_beat.qa     = req_first_index;
   assign req_beat.qb     = req_second_index;
   assign req_beat.placed = req_placed;
   assign req_beat.amount = req_amount;

   always_ff @(posedge clock) begin
      if (reset) begin
         qubit_count_ff   <= CNT_W'(16);
         nucleus_count_ff <= CNT_W'(16);
         outstanding_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_QUBIT_COUNT:   qubit_count_ff   <= csr_data;
               CSR_NUCLEUS_COUNT: nucleus_count_ff <= csr_data;
               default: ;
            endcase
         end
         outstanding_ff <= outstanding_ff + RSP_CNT_W'(req_accept && is_report)
                           - RSP_CNT_W'(rsp_accept);
      end
   end

   pcrt_lookup #(
      .MAX_QUBITS    (MAX_QUBITS),
      .MAX_NUCLEI    (MAX_NUCLEI),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lookup (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req           (req_beat),
      .qubit_count   (qubit_count_ff),
      .nucleus_count (nucleus_count_ff),
      .beat          (cost_beat),
      .gate_busy     (gate_busy)
   );

   pcrt_update #(
      .MAX_QUBITS (MAX_QUBITS)
   ) u_update (
      .clock    (clock),
      .reset    (reset),
      .beat     (cost_beat),
      .rsp_push (push),
      .rsp_data (push_data)
   );

   pcrt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_runtime   = out_data.runtime;
   assign rsp_aborted   = out_data.aborted;
   assign rsp_saturated = out_data.saturated;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("more reports in flight than queue entries");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("response beat with no report outstanding");

endmodule
